// ===== sv/raycast_wall_column_texturer_unit_defines.svh =====
// assertion helpers for the wall column texturer
`ifndef RAYCAST_WALL_COLUMN_TEXTURER_UNIT_DEFINES_SVH
`define RAYCAST_WALL_COLUMN_TEXTURER_UNIT_DEFINES_SVH

// same-cycle implication
`define RWCT_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rwct assertion failed");

// next-cycle implication
`define RWCT_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rwct assertion failed");

`endif

// ===== sv/rwct_pkg.sv =====
package rwct_pkg;

  localparam int unsigned SCREEN_ROWS = 512;
  localparam int unsigned TILE_UNITS  = 64;
  localparam int unsigned ANGLE_BITS  = 12;
  localparam int unsigned TURN_SHIFT  = 16 - ANGLE_BITS;
  localparam int unsigned COORD_SHIFT = $clog2(256 * TILE_UNITS);

  // numerator of the height division shifted down by the quotient width
  localparam logic [52:0] DIV_INIT =
    53'(longint'(TILE_UNITS * SCREEN_ROWS) << (36 - 25));
  localparam logic [24:0] HEIGHT_SAT = 25'h1FFFFFF;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  localparam logic [1:0] TEX_NORTH = 2'd0;
  localparam logic [1:0] TEX_SOUTH = 2'd1;
  localparam logic [1:0] TEX_EAST  = 2'd2;
  localparam logic [1:0] TEX_WEST  = 2'd3;

  typedef struct packed {
    logic       load_col;
    logic       sin_step;
    logic       mul_step;
    logic [1:0] step_sel;
    logic       div_init;
    logic       div_step;
    logic       mod_step;
    logic       fin;
    logic       pmul;
    logic       pdiv_step;
    logic       out_write;
    logic [1:0] out_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic pix_avail;
    logic out_free;
  } dp_stat_t;

  // texture size register clamped to 1..256
  function automatic logic [8:0] dim(input logic [8:0] v);
    logic [8:0] r;
    if (v == 9'd0) r = 9'd1;
    else if (v > 9'd256) r = 9'd256;
    else r = v;
    return r;
  endfunction

  // quarter-wave sine, Q1.14
  function automatic logic [14:0] sine_rom(input logic [6:0] k);
    logic [14:0] r;
    case (k)
      7'd0: r = 15'd0;         7'd1: r = 15'd402;     7'd2: r = 15'd804;
      7'd3: r = 15'd1205;      7'd4: r = 15'd1606;    7'd5: r = 15'd2006;
      7'd6: r = 15'd2404;      7'd7: r = 15'd2801;    7'd8: r = 15'd3196;
      7'd9: r = 15'd3590;      7'd10: r = 15'd3981;   7'd11: r = 15'd4370;
      7'd12: r = 15'd4756;     7'd13: r = 15'd5139;   7'd14: r = 15'd5520;
      7'd15: r = 15'd5897;     7'd16: r = 15'd6270;   7'd17: r = 15'd6639;
      7'd18: r = 15'd7005;     7'd19: r = 15'd7366;   7'd20: r = 15'd7723;
      7'd21: r = 15'd8076;     7'd22: r = 15'd8423;   7'd23: r = 15'd8765;
      7'd24: r = 15'd9102;     7'd25: r = 15'd9434;   7'd26: r = 15'd9760;
      7'd27: r = 15'd10080;    7'd28: r = 15'd10394;  7'd29: r = 15'd10702;
      7'd30: r = 15'd11003;    7'd31: r = 15'd11297;  7'd32: r = 15'd11585;
      7'd33: r = 15'd11866;    7'd34: r = 15'd12140;  7'd35: r = 15'd12406;
      7'd36: r = 15'd12665;    7'd37: r = 15'd12916;  7'd38: r = 15'd13160;
      7'd39: r = 15'd13395;    7'd40: r = 15'd13623;  7'd41: r = 15'd13842;
      7'd42: r = 15'd14053;    7'd43: r = 15'd14256;  7'd44: r = 15'd14449;
      7'd45: r = 15'd14635;    7'd46: r = 15'd14811;  7'd47: r = 15'd14978;
      7'd48: r = 15'd15137;    7'd49: r = 15'd15286;  7'd50: r = 15'd15426;
      7'd51: r = 15'd15557;    7'd52: r = 15'd15679;  7'd53: r = 15'd15791;
      7'd54: r = 15'd15893;    7'd55: r = 15'd15986;  7'd56: r = 15'd16069;
      7'd57: r = 15'd16143;    7'd58: r = 15'd16207;  7'd59: r = 15'd16261;
      7'd60: r = 15'd16305;    7'd61: r = 15'd16340;  7'd62: r = 15'd16364;
      7'd63: r = 15'd16379;
      default: r = 15'd16384;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/rwct_ctrl.sv =====
module rwct_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               req_type_i,
  output logic               in_ready_o,
  input  rwct_pkg::dp_stat_t stat_i,
  output rwct_pkg::dp_cmd_t  cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SIN   = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_DINIT = 4'd3;
  localparam logic [3:0] ST_DIV   = 4'd4;
  localparam logic [3:0] ST_FIN   = 4'd5;
  localparam logic [3:0] ST_PMUL  = 4'd6;
  localparam logic [3:0] ST_PDIV  = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] kind_q, kind_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    cmd_o.step_sel = cnt_q[1:0];
    cmd_o.out_kind = kind_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d = 5'd0;
          if (!req_type_i) begin
            cmd_o.load_col = 1'b1;
            state_d = ST_SIN;
          end else if (stat_i.pix_avail) begin
            state_d = ST_PMUL;
          end else begin
            kind_d  = rwct_pkg::KIND_EMPTY;
            state_d = ST_OUT;
          end
        end
      end
      ST_SIN: begin
        cmd_o.sin_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd2) begin
          cnt_d   = 5'd0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd2) state_d = ST_DINIT;
      end
      ST_DINIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d   = 5'd24;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        // texture column remainder needs 15 steps
        cmd_o.mod_step = (cnt_q >= 5'd10);
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) state_d = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        kind_d  = rwct_pkg::KIND_HEADER;
        state_d = ST_OUT;
      end
      ST_PMUL: begin
        cmd_o.pmul = 1'b1;
        cnt_d   = 5'd7;
        state_d = ST_PDIV;
      end
      ST_PDIV: begin
        cmd_o.pdiv_step = 1'b1;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          kind_d  = rwct_pkg::KIND_PIXEL;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_write = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 5'd0;
      kind_q  <= rwct_pkg::KIND_HEADER;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      kind_q  <= kind_d;
    end
  end

endmodule

// ===== sv/rwct_datapath.sv =====
module rwct_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rwct_pkg::dp_cmd_t  cmd_i,
  output rwct_pkg::dp_stat_t stat_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [8:0]         cfg_data_i,
  input  logic [11:0]        ray_angle_i,
  input  logic [11:0]        view_angle_i,
  input  logic [19:0]        hit_x_i,
  input  logic [19:0]        hit_y_i,
  input  logic [19:0]        eye_x_i,
  input  logic [19:0]        eye_y_i,
  input  logic               hit_on_horizontal_i,
  input  logic               step_x_positive_i,
  input  logic               step_y_positive_i,
  input  logic [9:0]         column_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [1:0]         kind_o,
  output logic [9:0]         screen_x_o,
  output logic [8:0]         screen_y_o,
  output logic [9:0]         wall_height_o,
  output logic [1:0]         texture_sel_o,
  output logic [7:0]         texel_x_o,
  output logic [7:0]         texel_y_o,
  output logic               last_pixel_o
);

  logic [8:0] cfg_q [8];

  // column setup
  logic [11:0]        ra_q, ca_q;
  logic signed [20:0] dx_q, dy_q;
  logic [19:0]        coord_q;
  logic [9:0]         col_in_q;
  logic [1:0]         tex_q;
  logic               mir_q;
  logic signed [15:0] cr_q, sr_q, cc_q;
  logic signed [37:0] p0_q, along_q;
  logic signed [53:0] dist_q;
  logic [52:0]        rem_q;
  logic [24:0]        q_q;
  logic [8:0]         mrem_q;
  logic [14:0]        mval_q;

  // stored column state
  logic [9:0]  cur_column_q, rows_total_q, row_index_q;
  logic [8:0]  top_row_q;
  logic [23:0] clip_q;
  logic [1:0]  cur_tex_q;
  logic [7:0]  cur_texel_x_q;

  // pixel division
  logic [25:0] prem_q;
  logic [7:0]  pbits_q, pq_q;

  logic       out_valid_q;
  logic [1:0] kind_q;
  logic [9:0] screen_x_q, wall_height_q;
  logic [8:0] screen_y_q;
  logic [1:0] tex_out_q;
  logic [7:0] texel_x_q, texel_y_q;
  logic       last_q;

  // sine unit
  logic [15:0]        phase;
  logic [14:0]        wq, r0, r1, mag;
  logic [6:0]         ridx;
  logic [8:0]         rdiff;
  logic [16:0]        rprod;
  logic signed [15:0] sine;

  always_comb begin
    case (cmd_i.step_sel)
      2'd0:    phase = {ra_q, {rwct_pkg::TURN_SHIFT{1'b0}}} + 16'h4000;
      2'd1:    phase = {ra_q, {rwct_pkg::TURN_SHIFT{1'b0}}};
      default: phase = {ca_q, {rwct_pkg::TURN_SHIFT{1'b0}}} + 16'h4000;
    endcase
    wq    = phase[14] ? (15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
    ridx  = wq[14:8];
    r0    = rwct_pkg::sine_rom(ridx);
    r1    = rwct_pkg::sine_rom(ridx + 7'd1);
    rdiff = 9'(r1 - r0);
    rprod = rdiff * wq[7:0];
    mag   = (ridx >= 7'd64) ? 15'd16384 : (r0 + 15'(rprod[16:8]));
    sine  = phase[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  // shared multiplier for the distance
  logic signed [53:0] ma, mb, prod;
  always_comb begin
    case (cmd_i.step_sel)
      2'd0:    begin ma = 54'(cr_q); mb = 54'(dx_q); end
      2'd1:    begin ma = 54'(sr_q); mb = 54'(dy_q); end
      default: begin ma = 54'(cc_q); mb = 54'(along_q); end
    endcase
    prod = ma * mb;
  end

  logic [8:0]  wtex, thtex;
  logic [28:0] cprod;
  logic [52:0] dist_u, dt;
  logic        dist_pos;
  logic [9:0]  mt;
  logic [24:0] hfull, hclip;
  logic [9:0]  hcol;
  logic [23:0] clip_d;
  logic [10:0] top_w;
  logic [24:0] psum;
  logic [33:0] pnum;
  logic [25:0] den;
  logic [26:0] pt;

  always_comb begin
    wtex     = rwct_pkg::dim(cfg_q[{tex_q, 1'b0}]);
    thtex    = rwct_pkg::dim(cfg_q[{cur_tex_q, 1'b1}]);
    cprod    = coord_q * wtex;
    dist_pos = !dist_q[53] && (dist_q != 54'sd0);
    dist_u   = dist_q[52:0];
    dt       = {rem_q[51:0], 1'b0};
    mt       = {mrem_q, mval_q[14]};
    if (!dist_pos) hfull = 25'd0;
    else if (dist_u <= rwct_pkg::DIV_INIT) hfull = rwct_pkg::HEIGHT_SAT;
    else hfull = q_q;
    if (hfull > 25'(rwct_pkg::SCREEN_ROWS)) begin
      hclip  = hfull - 25'(rwct_pkg::SCREEN_ROWS);
      clip_d = hclip[24:1];
      hcol   = 10'(rwct_pkg::SCREEN_ROWS);
    end else begin
      hclip  = 25'd0;
      clip_d = 24'd0;
      hcol   = hfull[9:0];
    end
    top_w = 11'(rwct_pkg::SCREEN_ROWS - rwct_pkg::SCREEN_ROWS / 2)
          + {2'b0, hcol[9:1]} - {1'b0, hcol};
    psum  = {15'd0, row_index_q} + {1'b0, clip_q};
    pnum  = psum * thtex;
    den   = {16'd0, rows_total_q} + {1'b0, clip_q, 1'b0};
    pt    = {prem_q, pbits_q[7]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 8; k++) cfg_q[k] <= 9'd64;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_col) begin
      ra_q     <= ray_angle_i;
      ca_q     <= view_angle_i - ray_angle_i;
      dx_q     <= $signed({1'b0, hit_x_i}) - $signed({1'b0, eye_x_i});
      dy_q     <= $signed({1'b0, hit_y_i}) - $signed({1'b0, eye_y_i});
      coord_q  <= hit_on_horizontal_i ? hit_x_i : hit_y_i;
      col_in_q <= column_i;
      if (hit_on_horizontal_i)
        tex_q <= step_y_positive_i ? rwct_pkg::TEX_SOUTH : rwct_pkg::TEX_NORTH;
      else
        tex_q <= step_x_positive_i ? rwct_pkg::TEX_EAST : rwct_pkg::TEX_WEST;
      mir_q <= hit_on_horizontal_i ? step_y_positive_i : !step_x_positive_i;
    end
    if (cmd_i.sin_step) begin
      case (cmd_i.step_sel)
        2'd0:    cr_q <= sine;
        2'd1:    sr_q <= sine;
        default: cc_q <= sine;
      endcase
    end
    if (cmd_i.mul_step) begin
      case (cmd_i.step_sel)
        2'd0:    p0_q <= prod[37:0];
        2'd1:    along_q <= p0_q - prod[37:0];
        default: dist_q <= prod;
      endcase
    end
    if (cmd_i.div_init) begin
      rem_q  <= rwct_pkg::DIV_INIT;
      q_q    <= 25'd0;
      mrem_q <= 9'd0;
      mval_q <= cprod[rwct_pkg::COORD_SHIFT +: 15];
    end
    if (cmd_i.div_step) begin
      if (dt >= dist_u) begin
        rem_q <= dt - dist_u;
        q_q   <= {q_q[23:0], 1'b1};
      end else begin
        rem_q <= dt;
        q_q   <= {q_q[23:0], 1'b0};
      end
    end
    if (cmd_i.mod_step) begin
      mrem_q <= (mt >= {1'b0, wtex}) ? 9'(mt - {1'b0, wtex}) : mt[8:0];
      mval_q <= {mval_q[13:0], 1'b0};
    end
    if (cmd_i.pmul) begin
      prem_q  <= pnum[33:8];
      pbits_q <= pnum[7:0];
      pq_q    <= 8'd0;
    end
    if (cmd_i.pdiv_step) begin
      if (pt >= {1'b0, den}) begin
        prem_q <= 26'(pt - {1'b0, den});
        pq_q   <= {pq_q[6:0], 1'b1};
      end else begin
        prem_q <= pt[25:0];
        pq_q   <= {pq_q[6:0], 1'b0};
      end
      pbits_q <= {pbits_q[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_column_q  <= '0;
      top_row_q     <= '0;
      rows_total_q  <= '0;
      row_index_q   <= '0;
      clip_q        <= '0;
      cur_tex_q     <= '0;
      cur_texel_x_q <= '0;
    end else begin
      if (cmd_i.fin) begin
        cur_column_q  <= col_in_q;
        top_row_q     <= top_w[8:0];
        rows_total_q  <= hcol;
        row_index_q   <= 10'd0;
        clip_q        <= clip_d;
        cur_tex_q     <= tex_q;
        cur_texel_x_q <= mir_q ? 8'(wtex - 9'd1 - mrem_q) : mrem_q[7:0];
      end
      if (cmd_i.out_write && (cmd_i.out_kind == rwct_pkg::KIND_PIXEL))
        row_index_q <= row_index_q + 10'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_write) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_write) begin
      kind_q        <= cmd_i.out_kind;
      screen_x_q    <= cur_column_q;
      screen_y_q    <= 9'd0;
      wall_height_q <= 10'd0;
      tex_out_q     <= 2'd0;
      texel_x_q     <= 8'd0;
      texel_y_q     <= 8'd0;
      last_q        <= 1'b0;
      case (cmd_i.out_kind)
        rwct_pkg::KIND_HEADER: begin
          screen_y_q    <= top_row_q;
          wall_height_q <= rows_total_q;
          tex_out_q     <= cur_tex_q;
          texel_x_q     <= cur_texel_x_q;
        end
        rwct_pkg::KIND_PIXEL: begin
          screen_y_q <= top_row_q + row_index_q[8:0];
          tex_out_q  <= cur_tex_q;
          texel_x_q  <= cur_texel_x_q;
          texel_y_q  <= pq_q;
          last_q     <= (row_index_q + 10'd1 == rows_total_q);
        end
        default: ;
      endcase
    end
  end

  assign stat_o.pix_avail = (row_index_q < rows_total_q);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign screen_x_o    = screen_x_q;
  assign screen_y_o    = screen_y_q;
  assign wall_height_o = wall_height_q;
  assign texture_sel_o = tex_out_q;
  assign texel_x_o     = texel_x_q;
  assign texel_y_o     = texel_y_q;
  assign last_pixel_o  = last_q;

endmodule

// ===== sv/raycast_wall_column_texturer_unit.sv =====
// column item: the result comes from the 25-step height divider;
// pixel item: the result comes from the 8-step texture row divider
// pixel item with no row left: an empty result; an output held by out_ready_i stalls the next write
// one item is in work at a time; the next is taken once the result sits in the output register
// reset: controller idle, output empty, column state zero, texture sizes 64
`include "raycast_wall_column_texturer_unit_defines.svh"

module raycast_wall_column_texturer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [11:0] ray_angle_i,
  input  logic [11:0] view_angle_i,
  input  logic [19:0] hit_x_i,
  input  logic [19:0] hit_y_i,
  input  logic [19:0] eye_x_i,
  input  logic [19:0] eye_y_i,
  input  logic        hit_on_horizontal_i,
  input  logic        step_x_positive_i,
  input  logic        step_y_positive_i,
  input  logic [9:0]  column_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [9:0]  screen_x_o,
  output logic [8:0]  screen_y_o,
  output logic [9:0]  wall_height_o,
  output logic [1:0]  texture_sel_o,
  output logic [7:0]  texel_x_o,
  output logic [7:0]  texel_y_o,
  output logic        last_pixel_o
);

  rwct_pkg::dp_cmd_t  cmd;
  rwct_pkg::dp_stat_t stat;

  rwct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rwct_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .ray_angle_i         (ray_angle_i),
    .view_angle_i        (view_angle_i),
    .hit_x_i             (hit_x_i),
    .hit_y_i             (hit_y_i),
    .eye_x_i             (eye_x_i),
    .eye_y_i             (eye_y_i),
    .hit_on_horizontal_i (hit_on_horizontal_i),
    .step_x_positive_i   (step_x_positive_i),
    .step_y_positive_i   (step_y_positive_i),
    .column_i            (column_i),
    .out_ready_i         (out_ready_i),
    .out_valid_o         (out_valid_o),
    .kind_o              (kind_o),
    .screen_x_o          (screen_x_o),
    .screen_y_o          (screen_y_o),
    .wall_height_o       (wall_height_o),
    .texture_sel_o       (texture_sel_o),
    .texel_x_o           (texel_x_o),
    .texel_y_o           (texel_y_o),
    .last_pixel_o        (last_pixel_o)
  );

  `RWCT_ASSERT_NXT(a_busy_after_transfer, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `RWCT_ASSERT_IMP(a_height_clamped, clk_i, rst_ni, out_valid_o && (kind_o == rwct_pkg::KIND_HEADER), wall_height_o <= 10'(rwct_pkg::SCREEN_ROWS))
  `RWCT_ASSERT_IMP(a_empty_fields_zero, clk_i, rst_ni, out_valid_o && (kind_o == rwct_pkg::KIND_EMPTY), (texel_y_o == 8'd0) && !last_pixel_o && (wall_height_o == 10'd0))

endmodule
